/* rtl/core/dvf_pkg.sv */
// Shared types and codes for the duplicate vertex filter.
// No dependencies; used by the top level under rtl/core.
package dvf_pkg;

  localparam int unsigned VERTEX_W = 32;

  // Command codes carried on s_tuser
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

/* rtl/core/dvf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dvf_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dvf_match.sv */
// Tag compare across all ways of one set and the replacement row.
// Depends on nothing but its parameters; instantiated by the top level.
module dvf_match #(
  parameter int unsigned TAG_BITS = 18,
  parameter int unsigned WAYS     = 4,
  parameter int unsigned PTR_W    = 2
) (
  input  logic [WAYS*TAG_BITS-1:0] row,
  input  logic [TAG_BITS-1:0]      tag,
  input  logic [PTR_W-1:0]         ptr,
  output logic                     hit,
  output logic [WAYS*TAG_BITS-1:0] row_next
);

  always_comb begin
    hit      = 1'b0;
    row_next = row;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w*TAG_BITS +: TAG_BITS] == tag) begin
        hit = 1'b1;
      end
      // replace the way named by the round-robin pointer
      if (ptr == PTR_W'(w)) begin
        row_next[w*TAG_BITS +: TAG_BITS] = tag;
      end
    end
  end

endmodule

/* rtl/core/duplicate_vertex_filter_unit.sv */
// Top level of the duplicate vertex filter: control, sweep counter, output register.
// Depends on dvf_pkg, dvf_ram and dvf_match.
//
//  channel  dir  fields (tdata / tuser)          transaction when
//  s_*      in   tdata: vertex[31:0]              s_tvalid & s_tready
//                tuser: cmd[0]
//  m_*      out  tdata: new_vertex[31:0]          m_tvalid & m_tready
//
// A filter transaction reads the set from the tag RAM in the accept cycle; the set is
// compared in the lookup state that follows and, on a miss, rewritten and forwarded.
// s_tready is low in lookup, so a new vertex is taken only once the last one leaves it.
// After reset and after every clear command a sweep writes all ones into the
// tag RAM, one set per cycle over all 2**INDEX_BITS sets, with s_tready low.
// A miss stalls in the lookup state only while the output register is full and
// m_tready is low; the input side waits meanwhile.
module duplicate_vertex_filter_unit #(
  parameter int unsigned INDEX_BITS = 14,
  parameter int unsigned WAYS       = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // vertex[31:0]
  input  logic [0:0]  s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // new_vertex[31:0]
);

  localparam int unsigned TAG_BITS = dvf_pkg::VERTEX_W - INDEX_BITS;
  localparam int unsigned SETS     = 1 << INDEX_BITS;
  localparam int unsigned ROW_W    = WAYS * TAG_BITS;
  localparam int unsigned PTR_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  dvf_pkg::state_t state, state_next;

  logic [INDEX_BITS-1:0] clr_addr;
  logic [PTR_W-1:0]      next_way;
  logic [31:0]           vertex;      // item under lookup
  logic                  s_acc;
  logic                  out_free;
  logic                  hit;
  logic                  out_load;
  logic                  sweep_done;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row_next;

  assign s_acc      = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign sweep_done = (clr_addr == {INDEX_BITS{1'b1}});

  dvf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (s_tdata[INDEX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  dvf_match #(
    .TAG_BITS (TAG_BITS),
    .WAYS     (WAYS),
    .PTR_W    (PTR_W)
  ) u_match (
    .row      (ram_rdata),
    .tag      (vertex[31:INDEX_BITS]),
    .ptr      (next_way),
    .hit      (hit),
    .row_next (row_next)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dvf_pkg::ST_SWEEP: begin
        if (sweep_done) state_next = dvf_pkg::ST_IDLE;
      end
      dvf_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_next = (s_tuser[0] == dvf_pkg::CMD_CLEAR) ? dvf_pkg::ST_SWEEP
                                                          : dvf_pkg::ST_LOOKUP;
        end
      end
      dvf_pkg::ST_LOOKUP: begin
        // a hit drops the vertex; a miss waits for room at the output
        if (hit || out_free) state_next = dvf_pkg::ST_IDLE;
      end
      default: state_next = dvf_pkg::ST_SWEEP;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = {ROW_W{1'b1}};
    out_load  = 1'b0;
    unique case (state)
      dvf_pkg::ST_SWEEP: begin
        ram_we = 1'b1;
      end
      dvf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid && (s_tuser[0] == dvf_pkg::CMD_FILTER);
      end
      dvf_pkg::ST_LOOKUP: begin
        out_load  = !hit && out_free;
        ram_we    = out_load;
        ram_waddr = vertex[INDEX_BITS-1:0];
        ram_wdata = row_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dvf_pkg::ST_SWEEP;
      clr_addr <= '0;
      next_way <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // advance the sweep; restart it on a clear command
      if (state == dvf_pkg::ST_SWEEP) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (s_acc && (s_tuser[0] == dvf_pkg::CMD_CLEAR)) begin
        next_way <= '0;
      end else if (out_load) begin
        next_way <= (next_way == PTR_W'(WAYS - 1)) ? '0 : next_way + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      vertex <= s_tdata;
    end
    if (out_load) begin
      m_tdata <= vertex;
    end
  end

  // Assertions
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tuser[0] == dvf_pkg::CMD_CLEAR)
      |=> (state == dvf_pkg::ST_SWEEP) && (next_way == '0) && (clr_addr == '0))
    else $error("clear command did not restart the sweep");

  a_filter_to_lookup: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tuser[0] == dvf_pkg::CMD_FILTER) |=> state == dvf_pkg::ST_LOOKUP)
    else $error("filter transaction did not enter lookup");

  a_miss_writes_tag: assert property (@(posedge clk) disable iff (rst)
    out_load |-> ram_we && !hit && (ram_waddr == vertex[INDEX_BITS-1:0]))
    else $error("forwarded vertex without tag write-back");

  a_sweep_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == dvf_pkg::ST_SWEEP) && sweep_done |=> state == dvf_pkg::ST_IDLE)
    else $error("sweep did not end in idle");

endmodule

/* tb/dvf_tb_pkg.sv */
// Scoreboard for the duplicate vertex filter testbench: tag tables, round-robin
// pointer and the queue of vertices expected on the output. Depends on dvf_pkg.
package dvf_tb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import dvf_pkg::*;

  localparam int unsigned IDX_W  = 14;
  localparam int unsigned N_WAYS = 4;
  localparam int unsigned TAG_W  = 32 - IDX_W;
  localparam int unsigned N_SETS = 1 << IDX_W;
  localparam logic [TAG_W-1:0] TAG_CLEARED = '1;

  class vertex_filter_sb;
    logic [TAG_W-1:0] tag_ram [N_WAYS][N_SETS];
    int unsigned      rr_way;
    logic [31:0]      pass_q [$];
    int               errors;

    function new();
      errors = 0;
      wipe_tags();
    endfunction

    function void wipe_tags();
      foreach (tag_ram[w, i]) tag_ram[w][i] = TAG_CLEARED;
      rr_way = 0;
    endfunction

    // Predict the outcome of one accepted transaction on the input side.
    function void note_input(logic cmd, logic [31:0] vtx);
      logic [IDX_W-1:0] idx;
      logic [TAG_W-1:0] tg;
      bit               seen;
      if (cmd == CMD_CLEAR) begin
        wipe_tags();
        return;
      end
      idx  = vtx[IDX_W-1:0];
      tg   = vtx[31:IDX_W];
      seen = 1'b0;
      for (int w = 0; w < N_WAYS; w++) begin
        if (tag_ram[w][idx] == tg) seen = 1'b1;
      end
      if (seen) return;
      pass_q.push_back(vtx);
      tag_ram[rr_way][idx] = tg;
      rr_way = (rr_way == N_WAYS - 1) ? 0 : rr_way + 1;
    endfunction

    // Compare one output transaction with the oldest pending vertex.
    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pass_q.size() == 0) begin
        $display("%0t: new_vertex unexpected: expected none, actual 0x%08h", $time, got);
        errors++;
        return;
      end
      want = pass_q.pop_front();
      if (got !== want) begin
        $display("%0t: new_vertex mismatch: expected 0x%08h, actual 0x%08h",
                 $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return pass_q.size();
    endfunction
  endclass

endpackage

/* tb/tb_duplicate_vertex_filter_unit.sv */
// Top-level testbench for duplicate_vertex_filter_unit: drives vertex and clear
// transactions, checks passed vertices against the scoreboard in dvf_tb_pkg.
// Depends on dvf_pkg, dvf_tb_pkg and the filter RTL.
module tb_duplicate_vertex_filter_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import dvf_pkg::*;
  import dvf_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 700;
  localparam int HOLD_CYCLES = 400;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = CMD_FILTER;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  vertex_filter_sb sb;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;   // bump to ask the receiver for a long hold-off
  int hold_ack    = 0;
  int hold_left   = 0;
  int clears_left = 6;   // each clear costs a full sweep of the tag RAM
  int cycle_cnt   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  duplicate_vertex_filter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // vertex[31:0]
    .s_tuser  (s_tuser),   // cmd[0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // new_vertex[31:0]
  );

  // Watchdog: end the run if the traffic never completes.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[duplicate_vertex_filter_unit] ERROR");
      $finish;
    end
  end

  // Monitor both channels at the edge. Check the output first: a result leaving
  // at this edge always belongs to an input accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_input(s_tuser[0], s_tdata);
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one transaction, with an optional idle gap ahead of it, and hold it
  // until the filter takes it (s_tready stays low through a tag sweep).
  task automatic send_item(input logic cmd, input logic [31:0] vtx);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= vtx;
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the input idle until every predicted vertex has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A handful of set indexes and tags, so that random traffic keeps hitting,
  // missing and evicting in the same sets.
  function automatic logic [IDX_W-1:0] pool_index(int k);
    case (k)
      0:       return 14'h0000;
      1:       return 14'h0001;
      2:       return 14'h02A5;
      3:       return 14'h1234;
      4:       return 14'h3FFE;
      default: return 14'h3FFF;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pool_tag(int k);
    case (k)
      0:       return 18'h00000;
      1:       return 18'h00001;
      2:       return 18'h00002;
      3:       return 18'h15555;
      4:       return 18'h2AAAA;
      5:       return 18'h20000;
      6:       return 18'h3FFFE;
      default: return TAG_CLEARED;
    endcase
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(999);
    if (pick < 4 && clears_left > 0) begin
      clears_left--;
      send_item(CMD_CLEAR, $urandom());
    end else if (pick < 850) begin
      send_item(CMD_FILTER, {pool_tag($urandom_range(7)), pool_index($urandom_range(5))});
    end else begin
      send_item(CMD_FILTER, $urandom());
    end
  endtask

  // One random phase; halfway through, ask the receiver to hold off while the
  // sender keeps offering, so the output register fills and s_tready drops.
  task automatic run_phase(input int n_items, input bit with_hold);
    for (int n = 0; n < n_items; n++) begin
      if (with_hold && n == n_items / 2) hold_req++;
      send_random();
    end
  endtask

  task automatic run_directed();
    send_item(CMD_FILTER, 32'h0000_0000);          // miss, fills way 0
    send_item(CMD_FILTER, 32'h0000_0000);          // hit, dropped
    send_item(CMD_FILTER, 32'hFFFF_FFFF);          // all-ones tag looks seen
    send_item(CMD_FILTER, 32'hFFFF_C000);          // same, set 0 still partly cleared
    // Fill all four ways of set 5, wrapping the round-robin pointer.
    send_item(CMD_FILTER, {18'h00001, 14'h0005});
    send_item(CMD_FILTER, {18'h00002, 14'h0005});
    send_item(CMD_FILTER, {18'h00003, 14'h0005});
    send_item(CMD_FILTER, {18'h00004, 14'h0005});
    send_item(CMD_FILTER, {TAG_CLEARED, 14'h0005}); // no cleared way left: passes
    send_item(CMD_FILTER, {18'h00001, 14'h0005});   // was evicted: passes again
    send_item(CMD_FILTER, {TAG_CLEARED, 14'h0005}); // now stored: dropped
    send_item(CMD_FILTER, 32'h0000_3FFF);
    send_item(CMD_FILTER, 32'hAAAA_AAAA);
    send_item(CMD_FILTER, 32'h5555_5555);
    send_item(CMD_FILTER, 32'hAAAA_AAAA);          // hit
    send_item(CMD_CLEAR,  32'hDEAD_BEEF);          // new search, payload ignored
    send_item(CMD_FILTER, 32'h0000_0000);          // forgotten by the clear
    send_item(CMD_FILTER, 32'hFFFF_FFFF);
    send_item(CMD_FILTER, {18'h00002, 14'h0005});
    drain();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Slow sender against a mostly stalled receiver.
    tx_idle_pct = 27;
    rx_idle_pct = 86;
    run_phase(PHASE_ITEMS, 1'b1);
    drain();

    // Mostly idle sender against a fast receiver.
    tx_idle_pct = 86;
    rx_idle_pct = 27;
    run_phase(PHASE_ITEMS, 1'b0);
    drain();

    // Full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(PHASE_ITEMS, 1'b1);
    drain();

    // Leave time for any stray output after the last expected vertex.
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[duplicate_vertex_filter_unit] OK");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected vertices never arrived", $time, sb.pending());
      $display("[duplicate_vertex_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
